### rtl/m3i_pkg.sv
`timescale 1ns / 1ps

package m3i_pkg;

    localparam int W        = 32;               // entry width, Q16.16
    localparam int ENTRIES  = 9;
    localparam int THR_W    = 31;
    localparam int PROD_W   = 64;               // exact Q32.32 product
    localparam int ADJ_W    = 65;               // exact cofactor, signed
    localparam int AMAG_W   = 64;               // cofactor magnitude
    localparam int DET_W    = 97;               // exact Q48.48 determinant, signed
    localparam int DMAG_W   = 96;               // determinant magnitude
    localparam int DQ_W     = DMAG_W + 1 - 32;  // rounded determinant magnitude
    localparam int QUO_W    = W + 1;            // quotient bits kept before saturation
    localparam int NUM_W    = AMAG_W + QUO_W + 1;
    localparam int DEN_W    = DMAG_W + 1;

    localparam int ADJ_LAT  = 2;
    localparam int DET_LAT  = 5;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int LATENCY  = ADJ_LAT + DET_LAT + DIV_LAT + 1;

    localparam logic [DMAG_W:0] ROUND_HALF = (DMAG_W + 1)'(1) << 31;

    // adjugate entry k = a[p]*a[q] - a[r]*a[s], inputs row-major
    localparam int ADJ_IDX [ENTRIES][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef logic signed [W-1:0]     entry_t;
    typedef logic signed [ADJ_W-1:0] adj_t;

    typedef struct packed {
        logic signed [W-1:0] a00;
        logic signed [W-1:0] a01;
        logic signed [W-1:0] a02;
        logic signed [W-1:0] a10;
        logic signed [W-1:0] a11;
        logic signed [W-1:0] a12;
        logic signed [W-1:0] a20;
        logic signed [W-1:0] a21;
        logic signed [W-1:0] a22;
    } m3i_in_t;

    typedef struct packed {
        logic signed [W-1:0] inv00;
        logic signed [W-1:0] inv01;
        logic signed [W-1:0] inv02;
        logic signed [W-1:0] inv10;
        logic signed [W-1:0] inv11;
        logic signed [W-1:0] inv12;
        logic signed [W-1:0] inv20;
        logic signed [W-1:0] inv21;
        logic signed [W-1:0] inv22;
        logic signed [W-1:0] determinant;
        logic                singular;
        logic                overflow;
    } m3i_out_t;

    // what travels beside the dividers
    typedef struct packed {
        logic [ENTRIES-1:0] neg;
        logic               sing;
        logic [W-1:0]       det;
        logic               det_ovf;
    } m3i_side_t;

    typedef struct packed {
        m3i_side_t                       side;
        logic [DEN_W-1:0]                den;
        logic [ENTRIES-1:0][NUM_W-1:0]   num;
    } m3i_dd_t;

    // saturate a sign and magnitude to 32 bits; result is {overflow, value}
    function automatic logic [W:0] sat32(input logic neg, input logic big,
                                         input logic [W:0] mag);
        logic         ov;
        logic [W-1:0] v;
        if (neg)
        begin
            ov = big || (mag > ((W + 1)'(1) << (W - 1)));
            v  = ov ? (W'(1) << (W - 1)) : W'(~mag[W-1:0] + W'(1));
        end
        else
        begin
            ov = big || (mag > (((W + 1)'(1) << (W - 1)) - (W + 1)'(1)));
            v  = ov ? ((W'(1) << (W - 1)) - W'(1)) : mag[W-1:0];
        end
        return {ov, v};
    endfunction

endpackage

### rtl/m3i_adj.sv
`timescale 1ns / 1ps

module m3i_adj
    import m3i_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    vld_in,
    input  m3i_in_t matrix,
    output logic    vld,
    output adj_t    adj  [ENTRIES],
    output entry_t  row0 [3]
);

    entry_t                    a [ENTRIES];
    logic signed [PROD_W-1:0]  pp_reg [ENTRIES];
    logic signed [PROD_W-1:0]  pq_reg [ENTRIES];
    adj_t                      adj_reg [ENTRIES];
    entry_t                    r0s1_reg [3];
    entry_t                    r0_reg [3];
    logic                      v1_reg;
    logic                      vld_reg;

    assign a[0] = matrix.a00;
    assign a[1] = matrix.a01;
    assign a[2] = matrix.a02;
    assign a[3] = matrix.a10;
    assign a[4] = matrix.a11;
    assign a[5] = matrix.a12;
    assign a[6] = matrix.a20;
    assign a[7] = matrix.a21;
    assign a[8] = matrix.a22;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            vld_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= vld_in;
            vld_reg <= v1_reg;
        end
    end

    // products, then cofactor differences
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            pp_reg[k]  <= a[ADJ_IDX[k][0]] * a[ADJ_IDX[k][1]];
            pq_reg[k]  <= a[ADJ_IDX[k][2]] * a[ADJ_IDX[k][3]];
            adj_reg[k] <= ADJ_W'(pp_reg[k]) - ADJ_W'(pq_reg[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            r0s1_reg[k] <= a[k];
            r0_reg[k]   <= r0s1_reg[k];
        end
    end

    assign vld  = vld_reg;
    assign adj  = adj_reg;
    assign row0 = r0_reg;

endmodule

### rtl/m3i_det.sv
`timescale 1ns / 1ps

module m3i_det
    import m3i_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vld_in,
    input  adj_t             adj  [ENTRIES],
    input  entry_t           row0 [3],
    input  logic [THR_W-1:0] thr,
    output logic             vld,
    output m3i_dd_t          dd
);

    localparam int HOLD = DET_LAT - 1;

    logic signed [ADJ_W-1:0] pl_reg [3];
    logic signed [ADJ_W-1:0] ph_reg [3];
    logic signed [DET_W-1:0] term_reg [3];
    logic signed [DET_W-1:0] det_reg;
    logic                    dneg_reg;
    logic [DMAG_W-1:0]       dmag_reg;
    logic [AMAG_W-1:0]       amag_reg [HOLD][ENTRIES];
    logic [ENTRIES-1:0]      asgn_reg [HOLD];
    logic [DET_LAT-1:0]      vpipe_reg;
    m3i_dd_t                 dd_reg;
    m3i_dd_t                 dd_next;

    logic signed [W:0]       clo [3];
    logic signed [W:0]       chi [3];
    logic [DMAG_W:0]         rnd;
    logic [DQ_W-1:0]         dq;
    logic [W:0]              dsat;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            clo[k] = {1'b0, adj[3 * k][W-1:0]};
            chi[k] = adj[3 * k][ADJ_W-1:W];
        end
    end

    // round the determinant, test for singular, build dividends
    always_comb
    begin
        rnd  = {1'b0, dmag_reg} + ROUND_HALF;
        dq   = rnd[DMAG_W:32];
        dsat = sat32(dneg_reg, |dq[DQ_W-1:W+1], dq[W:0]);
        dd_next.side.sing    = dq <= DQ_W'(thr);
        dd_next.side.det     = dsat[W-1:0];
        dd_next.side.det_ovf = dsat[W];
        dd_next.den          = {dmag_reg, 1'b0};
        for (int k = 0; k < ENTRIES; k++)
        begin
            dd_next.side.neg[k] = asgn_reg[HOLD-1][k] ^ dneg_reg;
            dd_next.num[k]      = NUM_W'({amag_reg[HOLD-1][k], (QUO_W)'(0)})
                                  + NUM_W'(dmag_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg <= '0;
        end
        else
        begin
            vpipe_reg <= {vpipe_reg[DET_LAT-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pl_reg[k]   <= row0[k] * clo[k];
            ph_reg[k]   <= row0[k] * chi[k];
            term_reg[k] <= (DET_W'(ph_reg[k]) <<< W) + DET_W'(pl_reg[k]);
        end
        det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
        dneg_reg <= det_reg[DET_W-1];
        dmag_reg <= DMAG_W'(det_reg[DET_W-1] ? -det_reg : det_reg);
        for (int k = 0; k < ENTRIES; k++)
        begin
            amag_reg[0][k] <= AMAG_W'(adj[k][ADJ_W-1] ? -adj[k] : adj[k]);
            asgn_reg[0][k] <= adj[k][ADJ_W-1];
        end
        for (int s = 1; s < HOLD; s++)
        begin
            amag_reg[s] <= amag_reg[s-1];
            asgn_reg[s] <= asgn_reg[s-1];
        end
        dd_reg <= dd_next;
    end

    assign vld = vpipe_reg[DET_LAT-1];
    assign dd  = dd_reg;

endmodule

### rtl/m3i_div.sv
`timescale 1ns / 1ps

module m3i_div
    import m3i_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             big
);

    logic [DEN_W-1:0] r_reg  [QUO_W+1];
    logic [QUO_W-1:0] lo_reg [QUO_W+1];
    logic [QUO_W-1:0] q_reg  [QUO_W+1];
    logic [DEN_W-1:0] d_reg  [QUO_W+1];
    logic             big_reg[QUO_W+1];

    logic [DEN_W:0]   t   [QUO_W];
    logic [DEN_W:0]   dif [QUO_W];
    logic             ge  [QUO_W];

    // one quotient bit per stage, restoring
    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            t[s]   = {r_reg[s], lo_reg[s][QUO_W-1]};
            dif[s] = t[s] - {1'b0, d_reg[s]};
            ge[s]  = t[s] >= {1'b0, d_reg[s]};
        end
    end

    always_ff @(posedge clk)
    begin
        // quotient of 2^33 or more saturates anyway
        r_reg[0]   <= DEN_W'(num[NUM_W-1:QUO_W]);
        lo_reg[0]  <= num[QUO_W-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= den;
        big_reg[0] <= DEN_W'(num[NUM_W-1:QUO_W]) >= den;
        for (int s = 0; s < QUO_W; s++)
        begin
            r_reg[s+1]   <= ge[s] ? dif[s][DEN_W-1:0] : t[s][DEN_W-1:0];
            lo_reg[s+1]  <= {lo_reg[s][QUO_W-2:0], 1'b0};
            q_reg[s+1]   <= {q_reg[s][QUO_W-2:0], ge[s]};
            d_reg[s+1]   <= d_reg[s];
            big_reg[s+1] <= big_reg[s];
        end
    end

    assign quo = q_reg[QUO_W];
    assign big = big_reg[QUO_W];

endmodule

### rtl/matrix3_inverse_top.sv
`timescale 1ns / 1ps

// 3x3 inverse of a signed Q16.16 matrix by adjugate over determinant. busy is
// always low: a transaction is taken on every cycle that start is high, one
// matrix per clock, and its result appears with done after it has gone through
// the cofactor products, then determinant, rounding and dividends, then the
// bit-per-stage dividers and last the saturation step. done lasts one cycle
// and cannot be held off, so capture result on that cycle. A determinant whose
// rounded magnitude is at or below the threshold marks the matrix singular and
// zeroes the inverse; determinant is reported regardless. Write the threshold
// through cfg_we/cfg_wdata only while no transaction is in flight.

module matrix3_inverse_top
    import m3i_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  m3i_in_t          matrix,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    output logic             done,
    output m3i_out_t         result
);

    logic [THR_W-1:0]   thr_reg;

    logic               adj_vld;
    adj_t               adj  [ENTRIES];
    entry_t             row0 [3];
    logic               dd_vld;
    m3i_dd_t            dd;

    logic [QUO_W-1:0]   quo [ENTRIES];
    logic               big [ENTRIES];

    // side data travels alongside the dividers
    m3i_side_t          side_reg [DIV_LAT];
    logic [DIV_LAT-1:0] sv_reg;

    logic [W-1:0]       inv  [ENTRIES];
    logic [ENTRIES-1:0] eovf;
    logic [W:0]         sat  [ENTRIES];
    m3i_side_t          last;
    m3i_out_t           result_next;
    m3i_out_t           result_reg;
    logic               done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    m3i_adj u_adj
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld_in (start),
        .matrix (matrix),
        .vld    (adj_vld),
        .adj    (adj),
        .row0   (row0)
    );

    m3i_det u_det
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld_in (adj_vld),
        .adj    (adj),
        .row0   (row0),
        .thr    (thr_reg),
        .vld    (dd_vld),
        .dd     (dd)
    );

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_div
        m3i_div u_div
        (
            .clk (clk),
            .num (dd.num[k]),
            .den (dd.den),
            .quo (quo[k]),
            .big (big[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            sv_reg   <= {sv_reg[DIV_LAT-2:0], dd_vld};
            done_reg <= sv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= dd.side;
        for (int s = 1; s < DIV_LAT; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
        result_reg <= result_next;
    end

    // saturate each quotient, then zero the inverse and its overflow for a singular matrix
    always_comb
    begin
        last = side_reg[DIV_LAT-1];
        for (int k = 0; k < ENTRIES; k++)
        begin
            sat[k]  = sat32(last.neg[k], big[k], quo[k]);
            inv[k]  = last.sing ? '0 : sat[k][W-1:0];
            eovf[k] = sat[k][W] & ~last.sing;
        end
        result_next.inv00       = inv[0];
        result_next.inv01       = inv[1];
        result_next.inv02       = inv[2];
        result_next.inv10       = inv[3];
        result_next.inv11       = inv[4];
        result_next.inv12       = inv[5];
        result_next.inv20       = inv[6];
        result_next.inv21       = inv[7];
        result_next.inv22       = inv[8];
        result_next.determinant = last.det;
        result_next.singular    = last.sing;
        result_next.overflow    = last.det_ovf | (|eovf);
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("transaction result missing at fixed latency");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.singular |->
            result.inv00 == 0 && result.inv01 == 0 && result.inv02 == 0 &&
            result.inv10 == 0 && result.inv11 == 0 && result.inv12 == 0 &&
            result.inv20 == 0 && result.inv21 == 0 && result.inv22 == 0)
        else $error("singular matrix with nonzero inverse");

    a_sing_novf: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.singular |-> !result.overflow)
        else $error("singular matrix flagged overflow");

endmodule
